### rtl/assert_macros.svh
// Assertion macros shared by the mailbox RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### rtl/fohm_pkg.sv
// Package for the mailbox: operation and status codes, sequencer states.
// Depends on nothing.
package fohm_pkg;
	localparam logic [1:0] OP_SEND = 2'd0;
	localparam logic [1:0] OP_RECV = 2'd1;
	localparam logic [1:0] OP_CLOSE = 2'd2;
	localparam logic [1:0] OP_STATS = 2'd3;
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_EMPTY = 3'd1;
	localparam logic [2:0] ST_FULL = 3'd2;
	localparam logic [2:0] ST_DROPPED = 3'd3;
	localparam logic [2:0] ST_CLOSED = 3'd4;
	localparam logic [1:0] CFG_HEAP_MODE = 2'd0;
	localparam logic [1:0] CFG_DROP = 2'd1;
	localparam logic [1:0] CFG_CAP = 2'd2;
	localparam logic [10:0] CAP_RESET = 11'd1000;
	typedef enum logic [3:0] {
		S_IDLE, S_RING_RD, S_UP_RD, S_UP_CMP, S_DN_TOP, S_DN_LAST,
		S_DN_RD_L, S_DN_RD_R, S_DN_CMP, S_DONE
	} seq_state_t;
endpackage

### rtl/fohm_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
module fohm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

### rtl/fifo_or_heap_mailbox_top.sv
// Top level of the mailbox: stream ports, sequencer and the entry store.
// Depends on fohm_pkg, fohm_ram and assert_macros.svh.
//
// Use: items arrive on the s_axis channel (op, tag, priority) and each item
// gives exactly one result item on m_axis (status, tag, priority, occupancy
// and the three statistics). Configuration is written through cfg_we,
// cfg_addr and cfg_data while no item is in flight.
// One item is worked at a time; s_axis_tready is high while the sequencer is
// idle. The entry store is one single-port RAM, so its accesses go in turn.
// Ring sends, close, statistics, rejected sends and receives on empty go
// straight to S_DONE; a ring receive first reads the store in S_RING_RD. A
// heap send passes S_UP_RD and S_UP_CMP for each level that the entry climbs
// toward the root. A heap receive takes the root in S_DN_TOP and the last
// entry in S_DN_LAST, then sifts down through S_DN_RD_L, S_DN_RD_R and
// S_DN_CMP for each level: the two child reads and the write of that level.
// The next item can be taken in the cycle after a result leaves S_DONE.
// The result sits in an output register; while the receiver stalls it holds
// there, one more item may be taken and its result waits in the sequencer.
// Reset clears pointers, counters and the closed flag and restores the
// configuration; the store needs no clearing and is undefined until written.
`include "assert_macros.svh"
module fifo_or_heap_mailbox_top import fohm_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int TAG_BITS = 32,
	parameter int PRIO_BITS = 3
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_addr,
	input logic [10:0] cfg_data,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// tdata: op[1:0], message_tag, msg_priority, zero fill to whole bytes
	input logic [((2+TAG_BITS+PRIO_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// tdata: status[2:0], out_tag, out_priority, occupancy[10:0],
	// received_total[31:0], dropped_total[31:0], peak_occupancy[10:0], zero fill
	output logic [((3+TAG_BITS+PRIO_BITS+11+32+32+11+7)/8)*8-1:0] m_axis_tdata
);
	localparam int AW = $clog2(DEPTH);
	localparam int EW = TAG_BITS + PRIO_BITS;
	localparam int CW = AW + 1;
	localparam int OW = ((3+TAG_BITS+PRIO_BITS+11+32+32+11+7)/8)*8;

	logic heap_q, drop_q;
	logic [10:0] cap_q;
	logic [AW-1:0] rp_q, wp_q;
	logic [CW-1:0] cnt_q, peak_q, ecap;
	logic closed_q;
	logic [31:0] rcv_q, drp_q;
	seq_state_t st_q, st_d;
	logic [AW-1:0] idx_q, big_q, par, lch, rch;
	logic [EW-1:0] cur_q, bige_q, res_e_q;
	logic [2:0] res_st_q, in_st;
	logic [OW-1:0] out_q;
	logic ovalid_q;
	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	logic [1:0] in_op;
	logic [TAG_BITS-1:0] in_tag;
	logic [PRIO_BITS-1:0] in_pri;
	logic acc, done, r_take;
	logic [CW:0] l_full, r_full;
	logic [AW-1:0] ptr_adv_r, ptr_adv_w;

	function automatic logic [PRIO_BITS-1:0] pr(input logic [EW-1:0] e);
		return e[EW-1 -: PRIO_BITS];
	endfunction

	fohm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_store (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// Effective capacity clamped to 1..DEPTH.
	always_comb begin
		if (cap_q == 11'd0)
			ecap = CW'(1);
		else if ({21'd0, cap_q} > 32'(DEPTH))
			ecap = CW'(DEPTH);
		else
			ecap = CW'(cap_q);
	end

	assign in_op = s_axis_tdata[1:0];
	assign in_tag = s_axis_tdata[2 +: TAG_BITS];
	assign in_pri = s_axis_tdata[2+TAG_BITS +: PRIO_BITS];

	assign s_axis_tready = (st_q == S_IDLE);
	assign acc = s_axis_tvalid && s_axis_tready;

	assign par = (idx_q - AW'(1)) >> 1;
	assign l_full = {1'b0, idx_q, 1'b1};
	assign r_full = {1'b0, idx_q, 1'b1} + (CW+1)'(1);
	assign lch = l_full[AW-1:0];
	assign rch = r_full[AW-1:0];

	assign ptr_adv_r = ((CW'(rp_q) + CW'(1)) >= ecap) ? '0 : rp_q + AW'(1);
	assign ptr_adv_w = ((CW'(wp_q) + CW'(1)) >= ecap) ? '0 : wp_q + AW'(1);

	// The right child lands during S_DN_CMP; bige_q holds the winner so far.
	assign r_take = (r_full < (CW+1)'(cnt_q)) && (pr(ram_rdata) > pr(bige_q));

	always_comb begin
		in_st = ST_OK;
		unique case (in_op)
			OP_SEND: begin
				if (closed_q)
					in_st = ST_CLOSED;
				else if (cnt_q >= ecap)
					in_st = drop_q ? ST_DROPPED : ST_FULL;
			end
			OP_RECV: begin
				if (cnt_q == '0)
					in_st = ST_EMPTY;
			end
			default: ;
		endcase
	end

	// Sequencer control. Sifting moves a hole; the carried entry in cur_q
	// is written once at its final place.
	always_comb begin
		st_d = st_q;
		ram_we = 1'b0;
		ram_addr = idx_q;
		ram_wdata = cur_q;
		done = 1'b0;
		unique case (st_q)
			S_IDLE: begin
				if (acc) begin
					st_d = S_DONE;
					unique case (in_op)
						OP_SEND: begin
							if (!closed_q && cnt_q < ecap) begin
								if (heap_q)
									st_d = S_UP_RD;
								else begin
									ram_we = 1'b1;
									ram_addr = wp_q;
									ram_wdata = {in_pri, in_tag};
								end
							end
						end
						OP_RECV: begin
							if (cnt_q != '0) begin
								ram_addr = heap_q ? '0 : rp_q;
								st_d = heap_q ? S_DN_TOP : S_RING_RD;
							end
						end
						default: ;
					endcase
				end
			end
			S_RING_RD: st_d = S_DONE;
			S_UP_RD: begin
				if (idx_q == '0) begin
					ram_we = 1'b1;
					st_d = S_DONE;
				end else begin
					ram_addr = par;
					st_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (pr(cur_q) <= pr(ram_rdata))
					st_d = S_DONE;
				else begin
					ram_wdata = ram_rdata;
					st_d = S_UP_RD;
				end
			end
			S_DN_TOP: begin
				// cnt_q already holds the count after removal: the last index.
				ram_addr = cnt_q[AW-1:0];
				st_d = (cnt_q == '0) ? S_DONE : S_DN_LAST;
			end
			S_DN_LAST: st_d = S_DN_RD_L;
			S_DN_RD_L: begin
				if (l_full >= (CW+1)'(cnt_q)) begin
					ram_we = 1'b1;
					st_d = S_DONE;
				end else begin
					ram_addr = lch;
					st_d = S_DN_RD_R;
				end
			end
			S_DN_RD_R: begin
				ram_addr = rch;
				st_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				ram_we = 1'b1;
				if (!r_take && big_q == idx_q)
					st_d = S_DONE;
				else begin
					ram_wdata = r_take ? ram_rdata : bige_q;
					st_d = S_DN_RD_L;
				end
			end
			S_DONE: begin
				if (!ovalid_q || m_axis_tready) begin
					done = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			heap_q <= 1'b0;
			drop_q <= 1'b0;
			cap_q <= CAP_RESET;
			rp_q <= '0;
			wp_q <= '0;
			cnt_q <= '0;
			peak_q <= '0;
			closed_q <= 1'b0;
			rcv_q <= '0;
			drp_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				unique case (cfg_addr)
					CFG_HEAP_MODE: heap_q <= cfg_data[0];
					CFG_DROP: drop_q <= cfg_data[0];
					CFG_CAP: cap_q <= cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready)
				ovalid_q <= 1'b0;
			if (done)
				ovalid_q <= 1'b1;
			if (acc) begin
				if (in_op == OP_CLOSE)
					closed_q <= 1'b1;
				if (in_op == OP_SEND && !closed_q) begin
					if (cnt_q >= ecap) begin
						if (drop_q)
							drp_q <= drp_q + 32'd1;
					end else begin
						cnt_q <= cnt_q + CW'(1);
						rcv_q <= rcv_q + 32'd1;
						if (cnt_q + CW'(1) > peak_q)
							peak_q <= cnt_q + CW'(1);
						if (!heap_q)
							wp_q <= ptr_adv_w;
					end
				end
				if (in_op == OP_RECV && cnt_q != '0) begin
					cnt_q <= cnt_q - CW'(1);
					if (!heap_q)
						rp_q <= ptr_adv_r;
				end
			end
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		if (acc) begin
			cur_q <= {in_pri, in_tag};
			idx_q <= (in_op == OP_SEND) ? cnt_q[AW-1:0] : '0;
			res_e_q <= '0;
			res_st_q <= in_st;
		end
		unique case (st_q)
			S_RING_RD: res_e_q <= ram_rdata;
			S_UP_CMP: if (pr(cur_q) > pr(ram_rdata)) idx_q <= par;
			S_DN_TOP: res_e_q <= ram_rdata;
			S_DN_LAST: cur_q <= ram_rdata;
			S_DN_RD_R: begin
				if (pr(ram_rdata) > pr(cur_q)) begin
					big_q <= lch;
					bige_q <= ram_rdata;
				end else begin
					big_q <= idx_q;
					bige_q <= cur_q;
				end
			end
			S_DN_CMP: begin
				if (r_take)
					idx_q <= rch;
				else if (big_q != idx_q)
					idx_q <= big_q;
			end
			default: ;
		endcase
		if (done)
			out_q <= OW'({11'(peak_q), drp_q, rcv_q, 11'(cnt_q), res_e_q, res_st_q});
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = out_q;

	`ASSERT_IMP(a_cnt_le_depth, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH), "count above depth")
	`ASSERT_NEXT(a_one_result, clk, arst_n, done, m_axis_tvalid, "result not presented")
	`ASSERT_IMP(a_busy_no_accept, clk, arst_n, st_q != S_IDLE, !s_axis_tready, "accept while busy")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result lost")
endmodule

### bench/testbench.sv
// Self-checking bench for the mailbox top: drives items on the input stream,
// predicts every result item in ring and heap mode and compares field by field.
// Depends on fohm_pkg and fifo_or_heap_mailbox_top.
`timescale 1ns / 100ps
module testbench import fohm_pkg::*;;

	localparam int DEPTH = 1024;
	localparam int SETTLE = 60;

	typedef struct packed {
		logic [3:0] pad;
		logic [10:0] peak;
		logic [31:0] dropped;
		logic [31:0] received;
		logic [10:0] occ;
		logic [2:0] prio;
		logic [31:0] tag;
		logic [2:0] status;
	} mbox_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [10:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// tdata: op[1:0], message_tag[33:2], msg_priority[36:34], zero fill
	logic [39:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// tdata: status, out_tag, out_priority, occupancy, received_total,
	// dropped_total, peak_occupancy, zero fill
	logic [127:0] m_axis_tdata;

	fifo_or_heap_mailbox_top dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the mailbox.
	logic [31:0] slot_tag [DEPTH];
	logic [2:0] slot_prio [DEPTH];
	int unsigned ring_rd, ring_wr, held, peak_held;
	logic mbox_shut;
	logic [31:0] sends_taken, sends_dropped;
	logic mode_heap, mode_drop;
	logic [10:0] cap_reg = CAP_RESET;

	mbox_result_t expected_results[$];
	int errors = 0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int unsigned usable_cap();
		int unsigned c;
		c = cap_reg;
		if (c == 0) c = 1;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	function automatic int unsigned next_slot(input int unsigned p);
		return (p + 1 >= usable_cap()) ? 0 : p + 1;
	endfunction

	function automatic void swap_slots(input int unsigned a, input int unsigned b);
		logic [31:0] t;
		logic [2:0] p;
		t = slot_tag[a]; p = slot_prio[a];
		slot_tag[a] = slot_tag[b]; slot_prio[a] = slot_prio[b];
		slot_tag[b] = t; slot_prio[b] = p;
	endfunction

	function automatic mbox_result_t mailbox_outcome(input logic [1:0] op,
			input logic [31:0] tag, input logic [2:0] prio);
		mbox_result_t r;
		int unsigned i, par, big, l, rt;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_SEND: begin
				if (mbox_shut) begin
					r.status = ST_CLOSED;
				end else if (held >= usable_cap()) begin
					if (mode_drop) begin
						sends_dropped++;
						r.status = ST_DROPPED;
					end else begin
						r.status = ST_FULL;
					end
				end else begin
					if (mode_heap) begin
						slot_tag[held] = tag; slot_prio[held] = prio;
						// Climb only while strictly above the parent.
						i = held;
						while (i > 0) begin
							par = (i - 1) / 2;
							if (slot_prio[i] <= slot_prio[par]) break;
							swap_slots(i, par);
							i = par;
						end
					end else begin
						slot_tag[ring_wr] = tag; slot_prio[ring_wr] = prio;
						ring_wr = next_slot(ring_wr);
					end
					held++;
					sends_taken++;
					if (held > peak_held) peak_held = held;
				end
			end
			OP_RECV: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else if (mode_heap) begin
					r.tag = slot_tag[0]; r.prio = slot_prio[0];
					slot_tag[0] = slot_tag[held-1]; slot_prio[0] = slot_prio[held-1];
					held--;
					// Left child wins ties; right only when strictly larger.
					i = 0;
					forever begin
						big = i; l = 2*i + 1; rt = 2*i + 2;
						if (l < held && slot_prio[l] > slot_prio[big]) big = l;
						if (rt < held && slot_prio[rt] > slot_prio[big]) big = rt;
						if (big == i) break;
						swap_slots(i, big);
						i = big;
					end
				end else begin
					r.tag = slot_tag[ring_rd]; r.prio = slot_prio[ring_rd];
					ring_rd = next_slot(ring_rd);
					held--;
				end
			end
			OP_CLOSE: mbox_shut = 1'b1;
			default: ;
		endcase
		r.occ = held[10:0];
		r.received = sends_taken;
		r.dropped = sends_dropped;
		r.peak = peak_held[10:0];
		return r;
	endfunction

	task automatic pause_random();
		int unsigned k, gap;
		k = $urandom_range(0, 19);
		gap = (k < 12) ? 0 : (k < 18) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_item(input logic [1:0] op, input logic [31:0] tag,
			input logic [2:0] prio);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, prio, tag, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_results.push_back(mailbox_outcome(op, tag, prio));
		pause_random();
	endtask

	task automatic wait_drained();
		if (s_axis_tvalid)
			s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
		wait_drained();
		cfg_we <= 1'b1; cfg_addr <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_HEAP_MODE: mode_heap = val[0];
			CFG_DROP: mode_drop = val[0];
			default: cap_reg = val;
		endcase
		@(posedge clk);
	endtask

	task automatic empty_mailbox();
		while (held > 0) send_item(OP_RECV, $urandom, 3'($urandom));
	endtask

	task automatic test_ring_basics();
		send_item(OP_STATS, 32'h0, 3'd0);
		send_item(OP_RECV, 32'h0, 3'd0);
		send_item(OP_SEND, 32'h0000_0000, 3'd0);
		send_item(OP_SEND, 32'hffff_ffff, 3'd7);
		send_item(OP_SEND, 32'h5555_aaaa, 3'd5);
		send_item(OP_STATS, 32'h1234_5678, 3'd3);
		repeat (4) send_item(OP_RECV, 32'hffff_ffff, 3'd7);
	endtask

	task automatic test_capacity_edges();
		write_reg(CFG_CAP, 11'd0);
		send_item(OP_SEND, 32'hdead_beef, 3'd2);
		send_item(OP_SEND, 32'hcafe_f00d, 3'd6);
		write_reg(CFG_DROP, 11'd1);
		send_item(OP_SEND, 32'h0bad_cafe, 3'd1);
		send_item(OP_RECV, 32'h0, 3'd0);
		write_reg(CFG_CAP, 11'd3);
		repeat (5) send_item(OP_SEND, $urandom, 3'($urandom));
		empty_mailbox();
	endtask

	task automatic test_heap_ties();
		write_reg(CFG_HEAP_MODE, 11'd1);
		write_reg(CFG_DROP, 11'd0);
		write_reg(CFG_CAP, 11'd2047);
		send_item(OP_SEND, 32'h1, 3'd4);
		send_item(OP_SEND, 32'h2, 3'd4);
		send_item(OP_SEND, 32'h3, 3'd4);
		send_item(OP_SEND, 32'h4, 3'd7);
		send_item(OP_SEND, 32'h5, 3'd0);
		empty_mailbox();
	endtask

	// Mostly sends while low, mostly receives while high, some statistics.
	task automatic random_traffic(input int n, input int unsigned target);
		int unsigned k;
		for (int j = 0; j < n; j++) begin
			k = $urandom_range(0, 99);
			if (k < 5)
				send_item(OP_STATS, $urandom, 3'($urandom));
			else if (k < 5 + ((held < target) ? 65 : 30))
				send_item(OP_SEND, $urandom, 3'($urandom));
			else
				send_item(OP_RECV, $urandom, 3'($urandom));
			if (j == n / 2) wait_drained();
		end
	endtask

	task automatic test_random_heap();
		random_traffic(150, 40);
		empty_mailbox();
		write_reg(CFG_CAP, 11'd6);
		write_reg(CFG_DROP, 11'd1);
		random_traffic(70, 8);
		empty_mailbox();
	endtask

	task automatic test_random_ring();
		write_reg(CFG_HEAP_MODE, 11'd0);
		write_reg(CFG_DROP, 11'd0);
		write_reg(CFG_CAP, 11'd7);
		random_traffic(90, 9);
		empty_mailbox();
		write_reg(CFG_CAP, 11'd1024);
		random_traffic(90, 60);
	endtask

	task automatic test_close();
		send_item(OP_SEND, 32'h7777_0001, 3'd3);
		send_item(OP_CLOSE, 32'h0, 3'd0);
		send_item(OP_SEND, 32'h7777_0002, 3'd6);
		send_item(OP_CLOSE, 32'h0, 3'd0);
		send_item(OP_STATS, 32'h0, 3'd0);
		empty_mailbox();
		send_item(OP_RECV, 32'h0, 3'd0);
		send_item(OP_SEND, 32'h7777_0003, 3'd1);
	endtask

	initial begin
		ring_rd = 0; ring_wr = 0; held = 0; peak_held = 0;
		mbox_shut = 1'b0; sends_taken = '0; sends_dropped = '0;
		mode_heap = 1'b0; mode_drop = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ring_basics();
		test_capacity_edges();
		test_heap_ties();
		test_random_heap();
		test_random_ring();
		test_close();
		wait_drained();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Receiver: runs of ready with stalls, mostly short and a few long.
	initial begin
		int unsigned k;
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			k = $urandom_range(0, 9);
			m_axis_tready <= 1'b0;
			repeat ((k < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		mbox_result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result item", got.status, 32'h0);
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status) report_mismatch("status", got.status, want.status);
				if (got.tag !== want.tag) report_mismatch("out_tag", got.tag, want.tag);
				if (got.prio !== want.prio) report_mismatch("out_priority", got.prio, want.prio);
				if (got.occ !== want.occ) report_mismatch("occupancy", got.occ, want.occ);
				if (got.received !== want.received)
					report_mismatch("received_total", got.received, want.received);
				if (got.dropped !== want.dropped)
					report_mismatch("dropped_total", got.dropped, want.dropped);
				if (got.peak !== want.peak)
					report_mismatch("peak_occupancy", got.peak, want.peak);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
